// ----- rtl/okd_pkg.sv -----
// ----------------------------------------------------------------------------
// okd_pkg
// Shared types and constants for the OOK pulse frame decoder.
// ----------------------------------------------------------------------------
package okd_pkg;

  localparam int COUNT_W      = 6;
  localparam int FRAME_W      = 24;
  localparam int ID_W         = 20;
  localparam int UNIT_W       = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;
  // index of the footer gap pulse (pulse 50 counted from 1)
  localparam logic [COUNT_W-1:0] FOOTER_IDX  = 6'd49;
  localparam logic [4:0]         PAIRS_MAX   = 5'd24;
  // inverted unit code that addresses all units
  localparam logic [2:0]         UNIT_ALL    = 3'd4;

  localparam int GAP_MIN_RST     = 6120;
  localparam int GAP_MAX_RST     = 6800;
  localparam int SHORT_LIMIT_RST = 410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_MIN     = 2'd0,
    REG_GAP_MAX     = 2'd1,
    REG_SHORT_LIMIT = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_t;

  // current train state as seen by the frame check
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] frame;
  } train_view_t;

  typedef struct packed {
    logic            accepted;
    logic [ID_W-1:0] device_id;
    logic [UNIT_W-1:0] unit_number;
    logic            switch_on;
  } result_t;

endpackage

// ----- rtl/okd_train.sv -----
// ----------------------------------------------------------------------------
// okd_train
// Pulse counter, open-pair register and frame bit register.
// ----------------------------------------------------------------------------
module okd_train
  import okd_pkg::*;
#(
  parameter int PULSE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [PULSE_BITS-1:0] pulse,
  input  logic                  last,
  output train_view_t           view,
  output logic [PULSE_BITS-1:0] first_half
);

  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [PULSE_BITS-1:0] first_r, first_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic [4:0]            pair;

  assign pair = count_r[COUNT_W-1:1];

  always_comb begin
    count_nxt = count_r;
    first_nxt = first_r;
    frame_nxt = frame_r;
    if (step) begin
      if (!count_r[0]) begin
        first_nxt = pulse;
      end else if ((pair < PAIRS_MAX) && (first_r > pulse)) begin
        frame_nxt = frame_r | (FRAME_W'(1) << pair);
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
      if (last) begin
        count_nxt = '0;
        first_nxt = '0;
        frame_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= '0;
      frame_r <= '0;
    end else begin
      count_r <= count_nxt;
      first_r <= first_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign view.count  = count_r;
  assign view.frame  = frame_r;
  assign first_half  = first_r;

endmodule

// ----- rtl/okd_check.sv -----
// ----------------------------------------------------------------------------
// okd_check
// Footer and length check, field extraction for a finished train.
// ----------------------------------------------------------------------------
module okd_check
  import okd_pkg::*;
#(
  parameter int PULSE_BITS = 16
) (
  input  train_view_t           view,
  input  logic [PULSE_BITS-1:0] first_half,
  input  logic [PULSE_BITS-1:0] pulse,
  input  logic [PULSE_BITS-1:0] gap_min,
  input  logic [PULSE_BITS-1:0] gap_max,
  input  logic [PULSE_BITS-1:0] short_limit,
  output result_t               result
);

  logic       ok;
  logic [2:0] unit_raw;

  assign ok = (view.count == FOOTER_IDX) && (first_half < short_limit) &&
              (pulse >= gap_min) && (pulse <= gap_max);

  assign unit_raw = ~view.frame[ID_W+2:ID_W];

  always_comb begin
    result = '0;
    if (ok) begin
      result.accepted  = 1'b1;
      result.device_id = view.frame[ID_W-1:0];
      result.switch_on = view.frame[FRAME_W-1];
      if (unit_raw == UNIT_ALL) begin
        result.unit_number = '0;
      end else begin
        result.unit_number = {1'b0, unit_raw} + UNIT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/ook_remote_pulse_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// ook_remote_pulse_frame_decoder
// Decodes 433 MHz OOK remote switch frames from a stream of pulse lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per pulse or gap duration,
//   with in_end_of_train set on the last pulse of a captured train.
//   Output channel (out_valid/out_ready): one beat per train, emitted for the
//   beat that carries end_of_train; accepted=0 and all fields zero when the
//   train fails the length or footer checks.
//   Config port (cfg_we/cfg_index/cfg_wdata): 0 gap_min, 1 gap_max,
//   2 short_limit; write only while the block is idle.
// Timing:
//   One beat per cycle while the output slot is free. The pulse update is
//   one compare and one bit set, done with the frame check in the accepting
//   cycle; the result is registered and valid the cycle after its input beat.
// Reset:
//   Synchronous, active low. Clears the train state and output valid and
//   loads the default gap window and short limit.
// Stall:
//   While a result waits and out_ready is low, in_ready is low for every
//   pulse, with or without end_of_train; out_ready high frees the slot in
//   the same cycle.
// ----------------------------------------------------------------------------
module ook_remote_pulse_frame_decoder
  import okd_pkg::*;
#(
  parameter int PULSE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PULSE_BITS-1:0] in_pulse_length,
  input  logic                  in_end_of_train,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic [ID_W-1:0]       out_device_id,
  output logic [UNIT_W-1:0]     out_unit_number,
  output logic                  out_switch_on,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PULSE_BITS-1:0] cfg_wdata
);

  // configuration registers
  logic [PULSE_BITS-1:0] gap_min_r;
  logic [PULSE_BITS-1:0] gap_max_r;
  logic [PULSE_BITS-1:0] short_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_min_r     <= PULSE_BITS'(GAP_MIN_RST);
      gap_max_r     <= PULSE_BITS'(GAP_MAX_RST);
      short_limit_r <= PULSE_BITS'(SHORT_LIMIT_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAP_MIN:     gap_min_r     <= cfg_wdata;
        REG_GAP_MAX:     gap_max_r     <= cfg_wdata;
        REG_SHORT_LIMIT: short_limit_r <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // handshake: input beat may enter whenever the output slot is free
  // or is being drained this cycle
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  logic    in_beat;

  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  train_view_t           view;
  logic [PULSE_BITS-1:0] first_half;
  result_t               result;

  okd_train #(.PULSE_BITS(PULSE_BITS)) u_train (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_beat),
    .pulse      (in_pulse_length),
    .last       (in_end_of_train),
    .view       (view),
    .first_half (first_half)
  );

  // check sees the state before this beat's update, plus the beat itself
  okd_check #(.PULSE_BITS(PULSE_BITS)) u_check (
    .view        (view),
    .first_half  (first_half),
    .pulse       (in_pulse_length),
    .gap_min     (gap_min_r),
    .gap_max     (gap_max_r),
    .short_limit (short_limit_r),
    .result      (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_beat && in_end_of_train) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, loaded only with a finished train
  always_ff @(posedge clk) begin
    if (in_beat && in_end_of_train) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_r.accepted;
  assign out_device_id   = out_r.device_id;
  assign out_unit_number = out_r.unit_number;
  assign out_switch_on   = out_r.switch_on;

endmodule
